// ===== src/odo_pkg.sv =====
// shared types, constants and arithmetic helpers of the omni wheel odometry core
`default_nettype none
package odo_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;
	localparam int COUNT_WIDTH_DEF = 32;

	// accumulator of the serial multiplier, holds a 50 by 25 bit product with margin
	localparam int ACC_W = 76;
	localparam int POSE_W = 48;
	localparam int VEL_W = 32;
	localparam int INC_W = 34;

	localparam longint Q30_ONE = 64'sd1 << 30;

	// kinematic matrix in Q16
	localparam logic signed [16:0] K_Y = 17'sd37837;
	localparam logic signed [16:0] K_XAB = 17'sd21845;
	localparam logic signed [16:0] K_XC = 17'sd43691;
	localparam logic signed [16:0] K_W = 17'sd9175;

	localparam logic [23:0] MPP_RESET = 24'd692055;
	localparam logic signed [15:0] GAIN_RESET = 16'sd4096;

	typedef enum logic [2:0] {
		REG_X_GAIN = 3'd0,
		REG_Y_GAIN = 3'd1,
		REG_MPP    = 3'd2,
		REG_POSE_X = 3'd3,
		REG_POSE_Y = 3'd4
	} reg_idx_t;

	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_ZERO   = 1'b1
	} opcode_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] wheel_count_a;
		logic [31:0] wheel_count_b;
		logic [31:0] wheel_count_c;
		logic [15:0] heading;
	} in_item_t;

	typedef struct packed {
		logic signed [47:0] pose_x;
		logic signed [47:0] pose_y;
		logic signed [47:0] delta_x;
		logic signed [47:0] delta_y;
		logic signed [31:0] local_vx;
		logic signed [31:0] local_vy;
		logic signed [31:0] local_w;
	} out_item_t;

	// divide by 2^s, rounding half away from zero
	function automatic logic signed [ACC_W-1:0] shr_round(
		input logic signed [ACC_W-1:0] v,
		input int unsigned s
	);
		logic [ACC_W-1:0] u;
		logic neg;
		neg = v[ACC_W-1];
		u = neg ? ACC_W'(-v) : ACC_W'(v);
		u = (u + (ACC_W'(1) << (s - 1))) >> s;
		return neg ? -$signed(u) : $signed(u);
	endfunction

	function automatic logic signed [VEL_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		if (v[ACC_W-1:VEL_W-1] == '0 || v[ACC_W-1:VEL_W-1] == '1)
			return v[VEL_W-1:0];
		return v[ACC_W-1] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
	endfunction

	function automatic logic signed [POSE_W-1:0] sat48(input logic signed [POSE_W:0] v);
		if (v[POSE_W] == v[POSE_W-1])
			return v[POSE_W-1:0];
		return v[POSE_W] ? {1'b1, {(POSE_W-1){1'b0}}} : {1'b0, {(POSE_W-1){1'b1}}};
	endfunction

	// travel clamped to +-2^47 before the gain
	function automatic logic signed [ACC_W-1:0] clamp_travel(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] lim;
		lim = $signed(ACC_W'(1) << 47);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// sin(pi/2 * f) in Q30, f in Q30 from 0 to 1, each product truncated toward zero
	function automatic longint quarter_sine(input longint f);
		longint z;
		longint p;
		z = (f * f) >>> 30;
		p = 61;
		p = -3864 + p * z / Q30_ONE;
		p = 172272 + p * z / Q30_ONE;
		p = -5026995 + p * z / Q30_ONE;
		p = 85569306 + p * z / Q30_ONE;
		p = -693598668 + p * z / Q30_ONE;
		p = 1686629713 + p * z / Q30_ONE;
		p = p * f / Q30_ONE;
		if (p < 0)
			p = 0;
		if (p > Q30_ONE)
			p = Q30_ONE;
		return p;
	endfunction

endpackage
`default_nettype wire

// ===== src/odo_if.sv =====
// handshake channels of the odometry core: sample input, result output, register writes
`default_nettype none
interface odo_in_if;
	logic valid;
	logic ready;
	odo_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface odo_out_if;
	logic valid;
	logic ready;
	odo_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface odo_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] addr;
	logic [47:0] data;
	modport source(output valid, output addr, output data, input ready);
	modport sink(input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ===== src/omni_wheel_odometry_core.sv =====
// three wheel omni odometry core with a bit-serial multiply-accumulate unit
// between input transfer and result valid an encoder sample runs nine passes of the serial multiplier
//   (three of 25 bits, two of 16, four of 32); no new input is taken until its result is registered
// a pose zero command skips the multiplier and goes from the delta step straight to the output step
// the next input is taken while a finished result still waits in the output register
// reset: arst_n clears control, registers to their defaults, pose and counts to zero
`default_nettype none
module omni_wheel_odometry_core #(
	parameter int SINE_TABLE_DEPTH = odo_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int COUNT_WIDTH = odo_pkg::COUNT_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	odo_in_if.sink in_ch,
	odo_out_if.source out_ch,
	odo_cfg_if.sink cfg
);

	localparam int ACC_W = odo_pkg::ACC_W;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

	typedef logic signed [31:0] rom_t [SINE_TABLE_DEPTH];

	// sine over a full turn in Q30, built at elaboration
	function automatic rom_t build_rom();
		rom_t t;
		longint q;
		longint r;
		longint f;
		longint v;
		for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
			q = (4 * longint'(k)) / SINE_TABLE_DEPTH;
			r = (4 * longint'(k)) % SINE_TABLE_DEPTH;
			f = (r << 30) / SINE_TABLE_DEPTH;
			v = q[0] ? odo_pkg::quarter_sine(odo_pkg::Q30_ONE - f) : odo_pkg::quarter_sine(f);
			t[k] = 32'(q[1] ? -v : v);
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_DELTA = 9'b000000010,
		S_SUMS  = 9'b000000100,
		S_LOAD  = 9'b000001000,
		S_RUN   = 9'b000010000,
		S_POST  = 9'b000100000,
		S_POSE  = 9'b001000000,
		S_DIFF  = 9'b010000000,
		S_OUT   = 9'b100000000
	} state_t;

	// multiplier passes in order: travel y, x, w; gain y, x; then the two rotations
	typedef enum logic [3:0] {
		P_MY = 4'd0, P_MX = 4'd1, P_MW = 4'd2, P_GY = 4'd3, P_GX = 4'd4,
		P_CY = 4'd5, P_SX = 4'd6, P_CX = 4'd7, P_SY = 4'd8
	} pass_t;

	state_t state_q;
	pass_t pass_q;

	// registers
	logic signed [15:0] x_gain_q, y_gain_q;
	logic [23:0] mpp_q;

	// captured item
	logic op_q;
	logic [COUNT_WIDTH-1:0] cur_q [3];
	logic [15:0] hd_q;

	// odometry state
	logic [COUNT_WIDTH-1:0] prev_cnt_q [3];
	logic signed [31:0] wd_q [3];
	logic started_q;
	logic signed [47:0] pose_x_q, pose_y_q, prev_x_q, prev_y_q;
	logic signed [47:0] dx_q, dy_q;

	// intermediate values
	logic signed [ACC_W-1:0] sum_q [3];
	logic signed [ACC_W-1:0] ry_q, rx_q;
	logic signed [31:0] vx_q, vy_q, w_q;
	logic [IDX_W-1:0] sidx_q, cidx_q;
	logic signed [31:0] sin_q, cos_q;
	logic signed [odo_pkg::INC_W-1:0] ix_q, iy_q;

	// serial multiply-accumulate
	logic signed [ACC_W-1:0] acc_q, a_q;
	logic [32:0] b_q;
	logic [5:0] nb_q, k_q;
	logic mac_last;
	logic signed [ACC_W-1:0] addend;

	logic out_valid_q;
	odo_pkg::out_item_t out_q;

	logic in_xfer, cfg_xfer;
	logic signed [31:0] d0, d1, d2;
	logic signed [33:0] dab, dsum;
	logic [15:0] hc;
	logic signed [48:0] pose_x_n, pose_y_n;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer = in_ch.valid && in_ch.ready;
	// register writes are taken only between items
	assign cfg.ready = (state_q == S_IDLE);
	assign cfg_xfer = cfg.valid && cfg.ready;
	assign out_ch.valid = out_valid_q;
	assign out_ch.data = out_q;

	assign d0 = wd_q[0];
	assign d1 = wd_q[1];
	assign d2 = wd_q[2];
	assign dab = 34'(d0) - 34'(d1);
	assign dsum = 34'(d0) + 34'(d1) + 34'(d2);
	assign hc = hd_q + 16'd16384;

	// top bit of the multiplier operand carries negative weight
	assign mac_last = (k_q == nb_q - 6'd1);
	assign addend = b_q[0] ? (mac_last ? -a_q : a_q) : '0;

	assign pose_x_n = 49'(pose_x_q) + 49'(ix_q);
	assign pose_y_n = 49'(pose_y_q) + 49'(iy_q);

	// sine rom, two registered read ports
	always_ff @(posedge clk) begin
		if (state_q == S_SUMS) begin
			sin_q <= SINE_ROM[sidx_q];
			cos_q <= SINE_ROM[cidx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pass_q <= P_MY;
			x_gain_q <= odo_pkg::GAIN_RESET;
			y_gain_q <= odo_pkg::GAIN_RESET;
			mpp_q <= odo_pkg::MPP_RESET;
			started_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				prev_cnt_q[i] <= '0;
				wd_q[i] <= '0;
			end
			pose_x_q <= '0;
			pose_y_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready)
				out_valid_q <= 1'b0;

			// register writes arrive only while idle
			if (cfg_xfer) begin
				case (cfg.addr)
					odo_pkg::REG_X_GAIN: x_gain_q <= cfg.data[15:0];
					odo_pkg::REG_Y_GAIN: y_gain_q <= cfg.data[15:0];
					odo_pkg::REG_MPP: mpp_q <= cfg.data[23:0];
					odo_pkg::REG_POSE_X: begin
						pose_x_q <= cfg.data;
						prev_x_q <= cfg.data;
					end
					odo_pkg::REG_POSE_Y: begin
						pose_y_q <= cfg.data;
						prev_y_q <= cfg.data;
					end
					default: ;
				endcase
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						op_q <= in_ch.data.opcode;
						cur_q[0] <= in_ch.data.wheel_count_a[COUNT_WIDTH-1:0];
						cur_q[1] <= in_ch.data.wheel_count_b[COUNT_WIDTH-1:0];
						cur_q[2] <= in_ch.data.wheel_count_c[COUNT_WIDTH-1:0];
						hd_q <= in_ch.data.heading;
						state_q <= S_DELTA;
					end
				end
				S_DELTA: begin
					if (op_q == odo_pkg::OP_ZERO) begin
						// pose zero command keeps counts and previous pose
						pose_x_q <= '0;
						pose_y_q <= '0;
						state_q <= S_OUT;
					end else begin
						// wrapping difference read as signed count width
						for (int i = 0; i < 3; i++) begin
							if (started_q)
								wd_q[i] <= 32'($signed(cur_q[i] - prev_cnt_q[i]));
							prev_cnt_q[i] <= cur_q[i];
						end
						started_q <= 1'b1;
						sidx_q <= IDX_W'((32'(hd_q) * SINE_TABLE_DEPTH) >> 16);
						cidx_q <= IDX_W'((32'(hc) * SINE_TABLE_DEPTH) >> 16);
						state_q <= S_SUMS;
					end
				end
				S_SUMS: begin
					// wheel sums in Q16 counts
					sum_q[0] <= ACC_W'(dab * 51'(odo_pkg::K_Y));
					sum_q[1] <= ACC_W'(51'(dab + 34'(d1) + 34'(d1)) * 51'(odo_pkg::K_XAB)
						- 51'(d2) * 51'(odo_pkg::K_XC));
					sum_q[2] <= ACC_W'(dsum * 51'(odo_pkg::K_W));
					pass_q <= P_MY;
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					k_q <= '0;
					case (pass_q)
						P_MY, P_MX, P_MW: begin
							a_q <= sum_q[pass_q[1:0]];
							b_q <= {9'd0, mpp_q};
							nb_q <= 6'd25;
							acc_q <= '0;
						end
						P_GY: begin
							a_q <= odo_pkg::clamp_travel(ry_q);
							b_q <= 33'(y_gain_q);
							nb_q <= 6'd16;
							acc_q <= '0;
						end
						P_GX: begin
							a_q <= odo_pkg::clamp_travel(rx_q);
							b_q <= 33'(x_gain_q);
							nb_q <= 6'd16;
							acc_q <= '0;
						end
						P_CY: begin
							a_q <= ACC_W'(cos_q);
							b_q <= 33'(vy_q);
							nb_q <= 6'd32;
							acc_q <= '0;
						end
						P_SX: begin
							a_q <= ACC_W'(sin_q);
							b_q <= 33'(vx_q);
							nb_q <= 6'd32;
						end
						P_CX: begin
							a_q <= ACC_W'(cos_q);
							b_q <= 33'(vx_q);
							nb_q <= 6'd32;
							acc_q <= '0;
						end
						P_SY: begin
							// subtracted term of the x rotation
							a_q <= -ACC_W'(sin_q);
							b_q <= 33'(vy_q);
							nb_q <= 6'd32;
						end
						default: ;
					endcase
					state_q <= S_RUN;
				end
				S_RUN: begin
					acc_q <= acc_q + addend;
					a_q <= a_q <<< 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 6'd1;
					if (mac_last)
						state_q <= S_POST;
				end
				S_POST: begin
					case (pass_q)
						P_MY: ry_q <= odo_pkg::shr_round(acc_q, 24);
						P_MX: rx_q <= odo_pkg::shr_round(acc_q, 24);
						P_MW: w_q <= odo_pkg::sat32(odo_pkg::shr_round(acc_q, 24));
						P_GY: vy_q <= odo_pkg::sat32(odo_pkg::shr_round(acc_q, 12));
						P_GX: vx_q <= odo_pkg::sat32(odo_pkg::shr_round(acc_q, 12));
						P_SX: iy_q <= odo_pkg::INC_W'(odo_pkg::shr_round(acc_q, 30));
						P_SY: ix_q <= odo_pkg::INC_W'(odo_pkg::shr_round(acc_q, 30));
						default: ;
					endcase
					if (pass_q == P_SY) begin
						state_q <= S_POSE;
					end else begin
						pass_q <= pass_t'(pass_q + 4'd1);
						state_q <= S_LOAD;
					end
				end
				S_POSE: begin
					pose_x_q <= odo_pkg::sat48(pose_x_n);
					pose_y_q <= odo_pkg::sat48(pose_y_n);
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					dx_q <= odo_pkg::sat48(49'(pose_x_q) - 49'(prev_x_q));
					dy_q <= odo_pkg::sat48(49'(pose_y_q) - 49'(prev_y_q));
					prev_x_q <= pose_x_q;
					prev_y_q <= pose_y_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					// wait for the output register to drain
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q <= 1'b1;
						out_q.pose_x <= pose_x_q;
						out_q.pose_y <= pose_y_q;
						if (op_q == odo_pkg::OP_ZERO) begin
							out_q.delta_x <= '0;
							out_q.delta_y <= '0;
							out_q.local_vx <= '0;
							out_q.local_vy <= '0;
							out_q.local_w <= '0;
						end else begin
							out_q.delta_x <= dx_q;
							out_q.delta_y <= dy_q;
							out_q.local_vx <= vx_q;
							out_q.local_vy <= vy_q;
							out_q.local_w <= w_q;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// an accepted item always starts with the delta step
	a_accept_delta: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_DELTA)
		else $error("accepted item did not enter delta step");

	// bit counter never passes the operand width
	a_mac_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RUN |-> k_q < nb_q)
		else $error("serial multiplier overran its operand");

	// once a sample has been seen the block stays started
	a_started: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(started_q))
		else $error("started flag dropped");

	// the result register is only loaded from the output step
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_OUT)
		else $error("result raised outside output step");

endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// testbench for the omni wheel odometry core: directed and random samples checked against a local predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #1 clk = ~clk;

	odo_in_if in_ch();
	odo_out_if out_ch();
	odo_cfg_if cfg();

	omni_wheel_odometry_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg)
	);

	// predictor state: registers, stored counts and the pose
	longint sine_lut[1024];
	longint gain_x, gain_y, mpp;
	logic [31:0] last_count[3];
	longint wheel_delta[3];
	bit counting;
	longint pose[2];
	longint prev_pose[2];

	odo_pkg::out_item_t expected_results[$];
	int errors = 0;
	longint cycles = 0;
	bit calm = 1'b0;	// no idling while set

	localparam longint P48_MAX = (64'sd1 <<< 47) - 1;
	localparam longint P48_MIN = -(64'sd1 <<< 47);

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint round_shift(input longint v, input int s);
		longint u;
		u = v < 0 ? -v : v;
		u = (u + (64'sd1 <<< (s - 1))) >>> s;
		return v < 0 ? -u : u;
	endfunction

	// sin(pi/2*f), Horner chain with truncating divides
	function automatic longint quarter_wave(input longint f);
		longint z, p;
		z = (f * f) >>> 30;
		p = 61;
		p = -3864 + p * z / (64'sd1 <<< 30);
		p = 172272 + p * z / (64'sd1 <<< 30);
		p = -5026995 + p * z / (64'sd1 <<< 30);
		p = 85569306 + p * z / (64'sd1 <<< 30);
		p = -693598668 + p * z / (64'sd1 <<< 30);
		p = 1686629713 + p * z / (64'sd1 <<< 30);
		return clip(p * f / (64'sd1 <<< 30), 0, 64'sd1 <<< 30);
	endfunction

	function automatic void fill_sine_lut();
		longint q, r, f, v;
		for (int k = 0; k < 1024; k++) begin
			q = (4 * k) / 1024;
			r = (4 * k) % 1024;
			f = (r <<< 30) / 1024;
			v = q[0] ? quarter_wave((64'sd1 <<< 30) - f) : quarter_wave(f);
			sine_lut[k] = q[1] ? -v : v;
		end
	endfunction

	// wheel sum in Q16 counts to travel in 2^-24 m
	function automatic longint travel_of(input longint s);
		logic [63:0] u, hi, lo, r;
		u = s < 0 ? -s : s;
		hi = u >> 32;
		lo = u & 64'hFFFF_FFFF;
		r = ((hi * mpp) << 8) + ((lo * mpp + (64'd1 << 23)) >> 24);
		return s < 0 ? -longint'(r) : longint'(r);
	endfunction

	function automatic longint gained(input longint r, input longint g);
		r = clip(r, -(64'sd1 <<< 47), 64'sd1 <<< 47);
		return clip(round_shift(r * g, 12), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
	endfunction

	function automatic void reset_odometry();
		gain_x = 4096;
		gain_y = 4096;
		mpp = 692055;
		counting = 1'b0;
		for (int i = 0; i < 3; i++) begin
			last_count[i] = '0;
			wheel_delta[i] = 0;
		end
		pose = '{0, 0};
		prev_pose = '{0, 0};
	endfunction

	function automatic void apply_register(input odo_pkg::reg_idx_t idx,
		input logic [47:0] val);
		case (idx)
			odo_pkg::REG_X_GAIN: gain_x = longint'($signed(val[15:0]));
			odo_pkg::REG_Y_GAIN: gain_y = longint'($signed(val[15:0]));
			odo_pkg::REG_MPP:    mpp = longint'(val[23:0]);
			odo_pkg::REG_POSE_X: begin
				pose[0] = longint'($signed(val));
				prev_pose[0] = pose[0];
			end
			odo_pkg::REG_POSE_Y: begin
				pose[1] = longint'($signed(val));
				prev_pose[1] = pose[1];
			end
			default: ;
		endcase
	endfunction

	// one odometry step, returns the expected result
	function automatic odo_pkg::out_item_t odometry_step(input odo_pkg::in_item_t it);
		odo_pkg::out_item_t res;
		logic [31:0] cnt[3];
		logic [31:0] diff;
		logic [15:0] hc;
		longint sx, sy, sw, vx, vy, w, sn, cs, ix, iy, dx, dy;
		dx = 0; dy = 0; vx = 0; vy = 0; w = 0;
		if (it.opcode == odo_pkg::OP_ZERO) begin
			pose = '{0, 0};
		end else begin
			cnt = '{it.wheel_count_a, it.wheel_count_b, it.wheel_count_c};
			for (int i = 0; i < 3; i++) begin
				diff = cnt[i] - last_count[i];
				if (counting)
					wheel_delta[i] = longint'($signed(diff));
				last_count[i] = cnt[i];
			end
			counting = 1'b1;
			sy = 37837 * (wheel_delta[0] - wheel_delta[1]);
			sx = 21845 * wheel_delta[0] + 21845 * wheel_delta[1] - 43691 * wheel_delta[2];
			sw = 9175 * (wheel_delta[0] + wheel_delta[1] + wheel_delta[2]);
			vy = gained(travel_of(sy), gain_y);
			vx = gained(travel_of(sx), gain_x);
			w = clip(travel_of(sw), -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
			hc = it.heading + 16'd16384;
			sn = sine_lut[it.heading[15:6]];
			cs = sine_lut[hc[15:6]];
			iy = round_shift(cs * vy + sn * vx, 30);
			ix = round_shift(cs * vx - sn * vy, 30);
			pose[1] = clip(pose[1] + iy, P48_MIN, P48_MAX);
			pose[0] = clip(pose[0] + ix, P48_MIN, P48_MAX);
			dy = clip(pose[1] - prev_pose[1], P48_MIN, P48_MAX);
			dx = clip(pose[0] - prev_pose[0], P48_MIN, P48_MAX);
			prev_pose = pose;
		end
		res.pose_x = pose[0][47:0];
		res.pose_y = pose[1][47:0];
		res.delta_x = dx[47:0];
		res.delta_y = dy[47:0];
		res.local_vx = vx[31:0];
		res.local_vy = vy[31:0];
		res.local_w = w[31:0];
		return res;
	endfunction

	function automatic bit idle_now();
		return !calm && ($urandom_range(99) < 17);
	endfunction

	// cycle limit: the run time of about 1200 items plus stalls, taken several times over
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3_000_000) begin
			$display("[omni_wheel_odometry_core] ERROR");
			$finish;
		end
	end

	// result side: random back-pressure and per-field compare
	always @(posedge clk) begin
		odo_pkg::out_item_t exp_r, got;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.data;
				if (expected_results.size() == 0) begin
					$error("result transfer with nothing expected");
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got.pose_x !== exp_r.pose_x) begin
						$error("pose_x exp %0d got %0d", exp_r.pose_x, got.pose_x); errors++;
					end
					if (got.pose_y !== exp_r.pose_y) begin
						$error("pose_y exp %0d got %0d", exp_r.pose_y, got.pose_y); errors++;
					end
					if (got.delta_x !== exp_r.delta_x) begin
						$error("delta_x exp %0d got %0d", exp_r.delta_x, got.delta_x); errors++;
					end
					if (got.delta_y !== exp_r.delta_y) begin
						$error("delta_y exp %0d got %0d", exp_r.delta_y, got.delta_y); errors++;
					end
					if (got.local_vx !== exp_r.local_vx) begin
						$error("local_vx exp %0d got %0d", exp_r.local_vx, got.local_vx); errors++;
					end
					if (got.local_vy !== exp_r.local_vy) begin
						$error("local_vy exp %0d got %0d", exp_r.local_vy, got.local_vy); errors++;
					end
					if (got.local_w !== exp_r.local_w) begin
						$error("local_w exp %0d got %0d", exp_r.local_w, got.local_w); errors++;
					end
				end
			end
			out_ch.ready <= !idle_now();
		end
	end

	// one input transfer, with a random gap before it; prediction made at acceptance
	task automatic send_item(input odo_pkg::in_item_t it);
		while (idle_now())
			@(posedge clk);
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do
			@(posedge clk);
		while (!in_ch.ready);
		expected_results.push_back(odometry_step(it));
		in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// register write, only while the core is idle
	task automatic write_register(input odo_pkg::reg_idx_t idx, input logic [47:0] val);
		cfg.valid <= 1'b1;
		cfg.addr <= idx;
		cfg.data <= val;
		do
			@(posedge clk);
		while (!cfg.ready);
		apply_register(idx, val);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic odo_pkg::in_item_t sample(input logic [31:0] a, b, c,
		input logic [15:0] h);
		odo_pkg::in_item_t it;
		it.opcode = odo_pkg::OP_SAMPLE;
		it.wheel_count_a = a;
		it.wheel_count_b = b;
		it.wheel_count_c = c;
		it.heading = h;
		return it;
	endfunction

	function automatic odo_pkg::in_item_t zero_cmd();
		odo_pkg::in_item_t it;
		it.opcode = odo_pkg::OP_ZERO;
		it.wheel_count_a = $urandom();
		it.wheel_count_b = $urandom();
		it.wheel_count_c = $urandom();
		it.heading = 16'($urandom());
		return it;
	endfunction

	// first sample, wraps, extremes of counts and headings, zero command
	task automatic test_directed();
		send_item(sample(32'hFFFF_FFF0, 32'd5, 32'h8000_0000, 16'd0));
		send_item(sample(32'h0000_0010, 32'hFFFF_FFFF, 32'h8000_0100, 16'd16384));
		send_item(sample(32'h0000_0110, 32'hFFFF_FF00, 32'h8000_0000, 16'd32768));
		send_item(sample(32'h8000_0110, 32'h7FFF_FF00, 32'h0, 16'hFFFF));
		send_item(sample(32'h0000_0110, 32'hFFFF_FF00, 32'h8000_0000, 16'd49152));
		send_item(zero_cmd());
		send_item(sample(32'h0000_0200, 32'h0000_0000, 32'h8000_0010, 16'h1234));
		send_item(sample(32'h0000_0200, 32'h0000_0000, 32'h8000_0010, 16'hABCD));
		send_item(sample(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8001));
		send_item(zero_cmd());
		drain();
	endtask

	// gain and scale extremes, pose near saturation
	task automatic test_registers();
		write_register(odo_pkg::REG_X_GAIN, 48'h0000_0000_7FFF);
		write_register(odo_pkg::REG_Y_GAIN, 48'h0000_0000_8000);
		write_register(odo_pkg::REG_MPP, 48'h0000_00FF_FFFF);
		write_register(odo_pkg::REG_POSE_X, 48'h7FFF_FFFF_0000);
		write_register(odo_pkg::REG_POSE_Y, 48'h8000_0000_1000);
		send_item(sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd8000));
		send_item(sample(32'hFFFF_FFFF, 32'h0, 32'h8000_0000, 16'd40000));
		send_item(sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'd0));
		send_item(sample(32'h0, 32'h0, 32'h0, 16'd24000));
		send_item(zero_cmd());
		drain();
		write_register(odo_pkg::REG_X_GAIN, 48'h0000_0000_0000);
		write_register(odo_pkg::REG_Y_GAIN, 48'h0000_0000_FFFF);
		write_register(odo_pkg::REG_MPP, 48'h0);
		send_item(sample(32'h1234, 32'h0, 32'h5, 16'd100));
		drain();
		write_register(odo_pkg::REG_POSE_X, 48'h8000_0000_0000);
		write_register(odo_pkg::REG_POSE_Y, 48'h7FFF_FFFF_FFFF);
		drain();
	endtask

	// mostly small steady motion, some large jumps, some zero commands
	task automatic test_random(input int n);
		logic [31:0] c[3];
		odo_pkg::in_item_t it;
		for (int i = 0; i < 3; i++)
			c[i] = $urandom();
		for (int k = 0; k < n; k++) begin
			calm = (k >= n / 3 && k < n / 3 + 60);
			case ($urandom_range(9))
				0: it = zero_cmd();
				1: begin
					for (int i = 0; i < 3; i++)
						c[i] = $urandom();
					it = sample(c[0], c[1], c[2], 16'($urandom()));
				end
				default: begin
					for (int i = 0; i < 3; i++)
						c[i] = c[i] + 32'($signed($urandom_range(4000)) - 2000);
					it = sample(c[0], c[1], c[2], 16'($urandom()));
				end
			endcase
			send_item(it);
		end
		calm = 1'b0;
		drain();
	endtask

	task automatic random_registers();
		write_register(odo_pkg::REG_X_GAIN, 48'($urandom_range(65535)));
		write_register(odo_pkg::REG_Y_GAIN, 48'($urandom_range(65535)));
		write_register(odo_pkg::REG_MPP, 48'($urandom_range(24'hFF_FFFF)));
		write_register(odo_pkg::REG_POSE_X, {$urandom(), 16'($urandom())});
		write_register(odo_pkg::REG_POSE_Y, {$urandom(), 16'($urandom())});
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.addr = odo_pkg::REG_X_GAIN;
		cfg.data = '0;
		fill_sine_lut();
		reset_odometry();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_registers();
		random_registers();
		test_random(400);
		write_register(odo_pkg::REG_X_GAIN, 48'h1000);
		write_register(odo_pkg::REG_Y_GAIN, 48'h1000);
		write_register(odo_pkg::REG_MPP, 48'd692055);
		test_random(400);
		random_registers();
		test_random(400);
		if (errors == 0)
			$display("[omni_wheel_odometry_core] OK");
		else
			$display("[omni_wheel_odometry_core] ERROR");
		$finish;
	end
endmodule
`default_nettype wire

// ===== omni_wheel_odometry_core.f =====
src/odo_pkg.sv
src/odo_if.sv
src/omni_wheel_odometry_core.sv
dv/tb_top.sv
